FILE: rtl/core/glp_pkg.sv
// shared constants and control structs for the greedy partition block
`timescale 1ns / 1ps
`default_nettype none
package glp_pkg;
    localparam int MAX_JOBS = 64;
    localparam int MAX_BINS = 16;
    localparam int WEIGHT_W = 16;
    localparam int LOAD_W   = 22;
    localparam int JOB_W    = $clog2(MAX_JOBS);
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int BIN_W    = $clog2(MAX_BINS);
    localparam int NBINS_W  = 5;
    localparam logic [NBINS_W-1:0] NUM_BINS_RESET = NBINS_W'(4);

    typedef struct packed {
        logic load;
        logic scan_clr;
        logic scan;
        logic bin_clr;
        logic bin_step;
        logic update;
        logic out_rd;
        logic out_next;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic bin_done;
        logic all_assigned;
        logic out_last;
    } status_t;
endpackage
`default_nettype wire

FILE: rtl/core/glp_ctrl.sv
// controller state machine for the greedy partition block
`timescale 1ns / 1ps
`default_nettype none
module glp_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_last,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire glp_pkg::status_t status,
    output glp_pkg::cmd_t         cmd
);
    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_BINS,
        S_UPDATE,
        S_OUT_RD,
        S_OUT_SHOW
    } state_t;

    state_t state_reg, state_next;
    logic in_ready_reg, out_valid_reg;

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                cmd.load     = in_valid;
                cmd.scan_clr = in_valid && in_last;
                if (in_valid && in_last)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    cmd.bin_clr = 1'b1;
                    state_next  = S_BINS;
                end
            end
            S_BINS:
            begin
                cmd.bin_step = 1'b1;
                if (status.bin_done)
                    state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.update   = 1'b1;
                cmd.scan_clr = 1'b1;
                state_next   = status.all_assigned ? S_OUT_RD : S_SCAN;
            end
            S_OUT_RD:
            begin
                cmd.out_rd = 1'b1;
                state_next = S_OUT_SHOW;
            end
            S_OUT_SHOW:
            begin
                if (out_ready)
                begin
                    cmd.out_next = 1'b1;
                    if (status.out_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_LOAD;
                    end
                    else
                        state_next = S_OUT_RD;
                end
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= (state_next == S_LOAD);
            out_valid_reg <= (state_next == S_OUT_SHOW);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/glp_dp.sv
// datapath: job store, selection scan, bin load search and result readout
`timescale 1ns / 1ps
`default_nettype none
module glp_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire glp_pkg::cmd_t                 cmd,
    output glp_pkg::status_t                   status,
    input  wire logic                          cfg_we,
    input  wire logic [glp_pkg::NBINS_W-1:0]   cfg_value,
    input  wire logic [glp_pkg::WEIGHT_W-1:0]  in_weight,
    output logic [glp_pkg::JOB_W-1:0]          out_job,
    output logic [glp_pkg::BIN_W-1:0]          out_bin,
    output logic                               out_overflow,
    output logic                               out_end
);
    logic [glp_pkg::WEIGHT_W-1:0] weight_mem [glp_pkg::MAX_JOBS];
    logic [glp_pkg::BIN_W-1:0]    assign_mem [glp_pkg::MAX_JOBS];
    logic [glp_pkg::LOAD_W-1:0]   load_reg   [glp_pkg::MAX_BINS];
    logic [glp_pkg::MAX_JOBS-1:0] taken_reg;

    logic [glp_pkg::NBINS_W-1:0]  num_bins_reg;
    logic [glp_pkg::CNT_W-1:0]    count_reg;
    logic                         dropped_reg;
    logic [glp_pkg::CNT_W-1:0]    j_reg;
    logic                         vld_d_reg;
    logic [glp_pkg::JOB_W-1:0]    idx_d_reg;
    logic [glp_pkg::WEIGHT_W-1:0] rd_w_reg;
    logic                         found_reg;
    logic [glp_pkg::JOB_W-1:0]    best_idx_reg;
    logic [glp_pkg::WEIGHT_W-1:0] best_w_reg;
    logic [glp_pkg::BIN_W-1:0]    b_reg;
    logic [glp_pkg::BIN_W-1:0]    best_bin_reg;
    logic [glp_pkg::LOAD_W-1:0]   min_reg;
    logic [glp_pkg::CNT_W-1:0]    k_reg;
    logic [glp_pkg::CNT_W-1:0]    o_reg;
    logic [glp_pkg::BIN_W-1:0]    asg_rd_reg;

    logic [glp_pkg::NBINS_W-1:0]  bins_eff;
    logic                         issue;
    logic                         take;

    // out-of-range bin counts are clamped
    always_comb
    begin
        if (num_bins_reg == '0)
            bins_eff = glp_pkg::NBINS_W'(1);
        else if (num_bins_reg > glp_pkg::NBINS_W'(glp_pkg::MAX_BINS))
            bins_eff = glp_pkg::NBINS_W'(glp_pkg::MAX_BINS);
        else
            bins_eff = num_bins_reg;
    end

    assign issue = cmd.scan && (j_reg != count_reg);
    // heavier wins; on equal weight the later (higher) index wins
    assign take  = vld_d_reg && !taken_reg[idx_d_reg] && (!found_reg || rd_w_reg >= best_w_reg);

    assign status.scan_done    = (j_reg == count_reg) && !vld_d_reg;
    assign status.bin_done     = (b_reg == glp_pkg::BIN_W'(bins_eff - glp_pkg::NBINS_W'(1)));
    assign status.all_assigned = (k_reg + glp_pkg::CNT_W'(1) == count_reg);
    assign status.out_last     = (o_reg + glp_pkg::CNT_W'(1) == count_reg);

    assign out_job      = o_reg[glp_pkg::JOB_W-1:0];
    assign out_bin      = asg_rd_reg;
    assign out_overflow = dropped_reg;
    assign out_end      = status.out_last;

    always_ff @(posedge clk)
    begin
        if (cmd.load && count_reg != glp_pkg::CNT_W'(glp_pkg::MAX_JOBS))
            weight_mem[count_reg[glp_pkg::JOB_W-1:0]] <= in_weight;
        rd_w_reg <= weight_mem[j_reg[glp_pkg::JOB_W-1:0]];
        if (cmd.update)
            assign_mem[best_idx_reg] <= best_bin_reg;
        if (cmd.out_rd)
            asg_rd_reg <= assign_mem[o_reg[glp_pkg::JOB_W-1:0]];
        idx_d_reg <= j_reg[glp_pkg::JOB_W-1:0];
        if (take)
        begin
            best_idx_reg <= idx_d_reg;
            best_w_reg   <= rd_w_reg;
        end
        if (cmd.bin_step && (b_reg == '0 || load_reg[b_reg] < min_reg))
        begin
            min_reg      <= load_reg[b_reg];
            best_bin_reg <= b_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_bins_reg <= glp_pkg::NUM_BINS_RESET;
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            j_reg        <= '0;
            vld_d_reg    <= 1'b0;
            found_reg    <= 1'b0;
            b_reg        <= '0;
            k_reg        <= '0;
            o_reg        <= '0;
            taken_reg    <= '0;
            for (int i = 0; i < glp_pkg::MAX_BINS; i++)
                load_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
                num_bins_reg <= cfg_value;
            if (cmd.load)
            begin
                if (count_reg != glp_pkg::CNT_W'(glp_pkg::MAX_JOBS))
                    count_reg <= count_reg + glp_pkg::CNT_W'(1);
                else
                    dropped_reg <= 1'b1;
            end
            if (cmd.scan_clr)
            begin
                j_reg     <= '0;
                vld_d_reg <= 1'b0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                vld_d_reg <= issue;
                if (issue)
                    j_reg <= j_reg + glp_pkg::CNT_W'(1);
                if (take)
                    found_reg <= 1'b1;
            end
            if (cmd.bin_clr)
                b_reg <= '0;
            else if (cmd.bin_step)
                b_reg <= b_reg + glp_pkg::BIN_W'(1);
            if (cmd.update)
            begin
                load_reg[best_bin_reg] <= min_reg + glp_pkg::LOAD_W'(best_w_reg);
                taken_reg[best_idx_reg] <= 1'b1;
                k_reg <= k_reg + glp_pkg::CNT_W'(1);
            end
            if (cmd.out_next)
                o_reg <= o_reg + glp_pkg::CNT_W'(1);
            if (cmd.finish)
            begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
                k_reg       <= '0;
                o_reg       <= '0;
                taken_reg   <= '0;
                for (int i = 0; i < glp_pkg::MAX_BINS; i++)
                    load_reg[i] <= '0;
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/greedy_lpt_partition.sv
// greedy longest-processing-time partition: top level
// loading takes one cycle per beat; a beat with tlast starts the assignment
// each of the n jobs then takes a selection scan over the weight memory
// (one read per cycle) and a min search over bin loads
// results follow in index order, one beat at a time; loading reopens next cycle
// reset is asynchronous, active low; num_bins resets to 4, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module greedy_lpt_partition (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // weight[15:0]
    input  wire logic        s_axis_tlast,   // last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // job_index[5:0], bin[9:6], zero[15:10]
    output logic             m_axis_tuser,   // overflow
    output logic             m_axis_tlast    // end_of_set
);
    glp_pkg::cmd_t    cmd;
    glp_pkg::status_t status;
    logic [glp_pkg::JOB_W-1:0] out_job;
    logic [glp_pkg::BIN_W-1:0] out_bin;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = {6'd0, out_bin, out_job};

    glp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    glp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_valid),
        .cfg_value    (cfg_data),
        .in_weight    (s_axis_tdata),
        .out_job      (out_job),
        .out_bin      (out_bin),
        .out_overflow (m_axis_tuser),
        .out_end      (m_axis_tlast)
    );
endmodule
`default_nettype wire

FILE: tb/greedy_lpt_partition_tb.sv
// testbench for the greedy longest-processing-time partition block
`timescale 1ns / 1ps
module greedy_lpt_partition_tb;
    typedef struct packed {
        logic [glp_pkg::JOB_W-1:0] job_index;
        logic [glp_pkg::BIN_W-1:0] bin;
        logic                      overflow;
        logic                      end_of_set;
    } placement_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    greedy_lpt_partition u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #1 clk = ~clk;

    // predictor state
    logic [glp_pkg::WEIGHT_W-1:0] set_weights[glp_pkg::MAX_JOBS];
    int                           set_count;
    logic                         set_dropped;
    logic [glp_pkg::NBINS_W-1:0]  bins_reg;
    placement_t                   expected_placements[$];

    int mismatches;
    int placements_seen;
    int sets_done;
    int hold_cycles;

    // close the set: heaviest first, ties higher index first, lightest bin wins
    task automatic place_set();
        int  order[glp_pkg::MAX_JOBS];
        logic [glp_pkg::LOAD_W-1:0] loads[glp_pkg::MAX_BINS];
        logic [glp_pkg::BIN_W-1:0]  where[glp_pkg::MAX_JOBS];
        int  bin_limit;
        int  k;
        int  tmp;
        int  best;
        placement_t p;
        bin_limit = (bins_reg == 0) ? 1 :
                    (bins_reg > glp_pkg::MAX_BINS ? glp_pkg::MAX_BINS : int'(bins_reg));
        for (int i = 0; i < set_count; i++)
            order[i] = i;
        for (int i = 1; i < set_count; i++)
        begin
            k = i;
            while (k > 0 && (set_weights[order[k]] > set_weights[order[k-1]] ||
                   (set_weights[order[k]] == set_weights[order[k-1]] &&
                    order[k] > order[k-1])))
            begin
                tmp = order[k]; order[k] = order[k-1]; order[k-1] = tmp;
                k--;
            end
        end
        for (int b = 0; b < glp_pkg::MAX_BINS; b++)
            loads[b] = '0;
        for (int i = 0; i < set_count; i++)
        begin
            best = 0;
            for (int b = 1; b < bin_limit; b++)
                if (loads[b] < loads[best])
                    best = b;
            where[order[i]] = glp_pkg::BIN_W'(best);
            loads[best] = loads[best] + glp_pkg::LOAD_W'(set_weights[order[i]]);
        end
        for (int i = 0; i < set_count; i++)
        begin
            p.job_index = glp_pkg::JOB_W'(i);
            p.bin = where[i];
            p.overflow = set_dropped;
            p.end_of_set = (i == set_count - 1);
            expected_placements.push_back(p);
        end
        set_count = 0;
        set_dropped = 1'b0;
    endtask

    // valid stays high into the next call when no gap is drawn
    task automatic send_job(input logic [15:0] weight, input logic last);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= weight;
        s_axis_tlast <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (set_count < glp_pkg::MAX_JOBS)
        begin
            set_weights[set_count] = weight;
            set_count++;
        end
        else
            set_dropped = 1'b1;
        if (last)
            place_set();
        @(negedge clk);
    endtask

    task automatic send_set(input int n, input int mode);
        logic [15:0] w;
        for (int i = 0; i < n; i++)
        begin
            case (mode)
                0: w = 16'($urandom);
                1: w = 16'($urandom_range(0, 3));
                default: w = 16'($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
            endcase
            send_job(w, i == n - 1);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_placements.size() != 0)
            @(negedge clk);
        // the block may still be tidying up after the final beat
        repeat (20) @(negedge clk);
    endtask

    task automatic write_num_bins(input logic [4:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        bins_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result checker with random receiver stalls
    initial
    begin
        placement_t want;
        placement_t got;
        int stall;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            if (m_axis_tvalid)
            begin
                got.job_index = m_axis_tdata[5:0];
                got.bin = m_axis_tdata[9:6];
                got.overflow = m_axis_tuser;
                got.end_of_set = m_axis_tlast;
                placements_seen++;
                if (got.end_of_set)
                    sets_done++;
                if (expected_placements.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: idx %0d bin %0d", got.job_index, got.bin);
                end
                else
                begin
                    want = expected_placements.pop_front();
                    if (got != want || m_axis_tdata[15:10] != '0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: want idx %0d bin %0d ovf %0b eos %0b,",
                                      " got idx %0d bin %0d ovf %0b eos %0b"},
                                     want.job_index, want.bin, want.overflow,
                                     want.end_of_set, got.job_index, got.bin,
                                     got.overflow, got.end_of_set);
                    end
                end
            end
        end
    end

    task automatic test_directed();
        send_job(16'hFFFF, 1'b1);
        wait_drained();
        send_job(16'h0000, 1'b0);
        send_job(16'hFFFF, 1'b0);
        send_job(16'h8000, 1'b0);
        send_job(16'h0001, 1'b0);
        send_job(16'h5555, 1'b0);
        send_job(16'hAAAA, 1'b1);
        // ties between equal weights
        for (int i = 0; i < 6; i++)
            send_job(16'h0100, i == 5);
        send_job(16'h0000, 1'b0);
        send_job(16'h0000, 1'b1);
        wait_drained();
    endtask

    task automatic test_bin_settings();
        logic [4:0] settings[6] = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd17, 5'd7};
        foreach (settings[i])
        begin
            write_num_bins(settings[i]);
            send_set($urandom_range(3, 12), i % 3);
            wait_drained();
        end
    endtask

    task automatic test_overflow();
        write_num_bins(5'd5);
        send_set(glp_pkg::MAX_JOBS + 3, 1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        send_set(16, 0);
        send_set(8, 2);
        wait_drained();
    endtask

    task automatic test_random();
        int n;
        write_num_bins(5'd4);
        for (int s = 0; s < 6; s++)
        begin
            n = $urandom_range(1, 12);
            send_set(n, $urandom_range(0, 2));
            if (s % 3 == 2)
            begin
                wait_drained();
                write_num_bins(5'($urandom));
            end
        end
        wait_drained();
    endtask

    initial
    begin
        set_count = 0;
        set_dropped = 1'b0;
        bins_reg = glp_pkg::NUM_BINS_RESET;
        mismatches = 0;
        placements_seen = 0;
        sets_done = 0;
        hold_cycles = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_bin_settings();
        test_overflow();
        test_backpressure();
        test_random();
        $display("covered %0d sets and %0d placements over bin counts 0..31,",
                 sets_done, placements_seen);
        $display("including ties, overflowing sets and a long output stall");
        if (mismatches == 0 && expected_placements.size() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches, %0d placements missing", mismatches,
                     expected_placements.size());
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("timeout");
        $display("TEST FAILED");
        $finish;
    end
endmodule
